[src/slsd_pkg.sv]
package slsd_pkg;

  // Store geometry
  localparam int SLOTS  = 64;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int VAL_W  = 32;

  // Fixed slots: free chain head and list header
  localparam logic [SLOT_W-1:0] FREE_HEAD   = SLOT_W'(0);
  localparam logic [SLOT_W-1:0] HEADER_SLOT = SLOT_W'(1);

  // Result action codes
  localparam logic [1:0] ACT_APPEND = 2'd0;
  localparam logic [1:0] ACT_INSERT = 2'd1;
  localparam logic [1:0] ACT_REMOVE = 2'd2;
  localparam logic [1:0] ACT_FULL   = 2'd3;

  // Request op codes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_APPLY = 1'b1;

  // Link contents after reset: free chain 0 -> 2 -> 3 -> ... -> last -> 0,
  // header and last slot point at 0
  function automatic logic [SLOT_W-1:0] init_link(input logic [SLOT_W-1:0] idx);
    logic [SLOT_W-1:0] res;
    if (idx == FREE_HEAD) begin
      res = SLOT_W'(2);
    end else if (idx == HEADER_SLOT || idx == SLOT_W'(SLOTS - 1)) begin
      res = '0;
    end else begin
      res = idx + 1'b1;
    end
    return res;
  endfunction

endpackage

[src/static_list_symmetric_difference_unit.sv]
// Static linked-list set with symmetric-difference update.
//
// Requests: raise start with op and value; the request is taken at a clock
// edge where start is high and busy is low. busy stays high until the result
// is out. Each request gives exactly one result, shown on action, slot and
// count for a single cycle with done high; the receiver cannot stall it, so
// it must take the result in that cycle.
//
// Steps: a load takes the free head slot and links it in at the tail. An
// apply reads the stop slot and first node, walks the A part one node per
// cycle (at most SLOTS), then unlinks and frees a hit or inserts the value
// after the tail. The walk is bound by the single read port of each memory.
// busy drops in the same cycle that done is high, so the next request may
// be taken right at that edge.
//
// Reset (rst, synchronous): the link memory is rebuilt to the initial free
// chain by a pass over all SLOTS slots, one slot a cycle, with busy high.
module static_list_symmetric_difference_unit
  import slsd_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic                    op,
  input  logic signed [VAL_W-1:0] value,
  output logic                    done,
  output logic [1:0]              action,
  output logic [5:0]              slot,
  output logic [5:0]              count
);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_STOP,
    ST_FIRST,
    ST_PROBE,
    ST_CMP,
    ST_ALLOC_REQ,
    ST_ALLOC,
    ST_RELINK_FREE,
    ST_SPLICE,
    ST_LINK_TAIL,
    ST_UNLINK,
    ST_FREE_LINK,
    ST_FREE_HEAD
  } state_t;

  state_t state;

  // Control registers
  logic [SLOT_W-1:0] clr_idx;
  logic [SLOT_W-1:0] a_tail;
  logic [SLOT_W-1:0] item_count;

  // Request and walk registers
  logic              req_op;
  logic [VAL_W-1:0]  req_value;
  logic [SLOT_W-1:0] stop_slot;
  logic [SLOT_W-1:0] cur;
  logic [SLOT_W-1:0] prev;
  logic [SLOT_W-1:0] succ;
  logic [SLOT_W-1:0] new_slot;
  logic [SLOT_W-1:0] steps;

  // Memory ports
  logic [SLOT_W-1:0] rd_addr;
  logic              lk_we;
  logic [SLOT_W-1:0] lk_waddr;
  logic [SLOT_W-1:0] lk_wdata;
  logic [SLOT_W-1:0] lk_rdata;
  logic              val_we;
  logic [VAL_W-1:0]  val_rdata;

  logic accept;
  logic hit;

  assign accept = start && !busy;
  assign busy   = (state != ST_IDLE);
  assign hit    = (val_rdata == req_value);

  slsd_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_link_ram (
    .clk   (clk),
    .we    (lk_we),
    .waddr (lk_waddr),
    .wdata (lk_wdata),
    .raddr (rd_addr),
    .rdata (lk_rdata)
  );

  slsd_ram #(.WIDTH(VAL_W), .DEPTH(SLOTS)) u_value_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (new_slot),
    .wdata (req_value),
    .raddr (rd_addr),
    .rdata (val_rdata)
  );

  // Memory addressing and writes per sequencer step
  always_comb begin
    rd_addr  = FREE_HEAD;
    lk_we    = 1'b0;
    lk_waddr = FREE_HEAD;
    lk_wdata = '0;
    val_we   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        lk_we    = 1'b1;
        lk_waddr = clr_idx;
        lk_wdata = init_link(clr_idx);
      end
      ST_IDLE: begin
        rd_addr = (op == OP_APPLY) ? a_tail : FREE_HEAD;
      end
      ST_STOP: begin
        rd_addr = HEADER_SLOT;
      end
      ST_FIRST: begin
        rd_addr = FREE_HEAD;
      end
      ST_PROBE: begin
        rd_addr = cur;
      end
      ST_CMP: begin
        rd_addr = lk_rdata;
      end
      ST_ALLOC_REQ: begin
        rd_addr = FREE_HEAD;
      end
      ST_ALLOC: begin
        rd_addr = lk_rdata;
      end
      ST_RELINK_FREE: begin
        // free head moves past the taken slot
        lk_we    = 1'b1;
        lk_waddr = FREE_HEAD;
        lk_wdata = lk_rdata;
        rd_addr  = a_tail;
      end
      ST_SPLICE: begin
        lk_we    = 1'b1;
        lk_waddr = new_slot;
        lk_wdata = lk_rdata;
        val_we   = 1'b1;
      end
      ST_LINK_TAIL: begin
        lk_we    = 1'b1;
        lk_waddr = a_tail;
        lk_wdata = new_slot;
      end
      ST_UNLINK: begin
        lk_we    = 1'b1;
        lk_waddr = prev;
        lk_wdata = succ;
        rd_addr  = FREE_HEAD;
      end
      ST_FREE_LINK: begin
        lk_we    = 1'b1;
        lk_waddr = cur;
        lk_wdata = lk_rdata;
      end
      ST_FREE_HEAD: begin
        lk_we    = 1'b1;
        lk_waddr = FREE_HEAD;
        lk_wdata = cur;
      end
      default: begin
        rd_addr = FREE_HEAD;
      end
    endcase
  end

  // Sequencer, list registers and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_idx    <= '0;
      a_tail     <= HEADER_SLOT;
      item_count <= '0;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == SLOT_W'(SLOTS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            req_op    <= op;
            req_value <= value;
            state     <= (op == OP_APPLY) ? ST_STOP : ST_ALLOC;
          end
        end
        ST_STOP: begin
          stop_slot <= lk_rdata;
          state     <= ST_FIRST;
        end
        ST_FIRST: begin
          cur   <= lk_rdata;
          prev  <= HEADER_SLOT;
          steps <= '0;
          state <= ST_PROBE;
        end
        ST_PROBE: begin
          state <= (cur == stop_slot) ? ST_ALLOC_REQ : ST_CMP;
        end
        ST_CMP: begin
          if (hit) begin
            succ  <= lk_rdata;
            state <= ST_UNLINK;
          end else begin
            // advance; next node read is already issued
            prev  <= cur;
            cur   <= lk_rdata;
            steps <= steps + 1'b1;
            if (steps == SLOT_W'(SLOTS - 1) || lk_rdata == stop_slot) begin
              state <= ST_ALLOC_REQ;
            end
          end
        end
        ST_ALLOC_REQ: begin
          state <= ST_ALLOC;
        end
        ST_ALLOC: begin
          new_slot <= lk_rdata;
          if (lk_rdata == FREE_HEAD) begin
            // store full: nothing changes
            done   <= 1'b1;
            action <= ACT_FULL;
            slot   <= '0;
            count  <= 6'(item_count);
            state  <= ST_IDLE;
          end else begin
            state <= ST_RELINK_FREE;
          end
        end
        ST_RELINK_FREE: begin
          state <= ST_SPLICE;
        end
        ST_SPLICE: begin
          state <= ST_LINK_TAIL;
        end
        ST_LINK_TAIL: begin
          if (req_op == OP_LOAD) begin
            a_tail <= new_slot;
          end
          item_count <= item_count + 1'b1;
          done       <= 1'b1;
          action     <= (req_op == OP_LOAD) ? ACT_APPEND : ACT_INSERT;
          slot       <= 6'(new_slot);
          count      <= 6'(item_count + 1'b1);
          state      <= ST_IDLE;
        end
        ST_UNLINK: begin
          state <= ST_FREE_LINK;
        end
        ST_FREE_LINK: begin
          state <= ST_FREE_HEAD;
        end
        ST_FREE_HEAD: begin
          // tail steps back when the tail node itself was removed
          if (a_tail == cur) begin
            a_tail <= prev;
          end
          if (item_count != '0) begin
            item_count <= item_count - 1'b1;
            count      <= 6'(item_count - 1'b1);
          end else begin
            count <= '0;
          end
          done   <= 1'b1;
          action <= ACT_REMOVE;
          slot   <= 6'(cur);
          state  <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[src/slsd_ram.sv]
module slsd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port (read-first)
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/slsd_checker.sv]
module slsd_checker
  import slsd_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic [1:0] action,
  input logic [5:0] slot
);

  // Accepted request keeps the unit busy until its result
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request accepted but busy not raised");

  // A result closes the request: unit is free in the result cycle
  a_done_free: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while still busy");

  // One result per request: no back-to-back strobes
  a_single_result: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

  // Store full reports slot zero
  a_full_slot: assert property (@(posedge clk) disable iff (rst)
    (done && action == ACT_FULL) |-> (slot == 6'd0))
    else $error("store full result with nonzero slot");

  // Removal frees a real data slot, never the free head or header
  a_remove_slot: assert property (@(posedge clk) disable iff (rst)
    (done && action == ACT_REMOVE) |-> (slot != 6'd0 && slot != 6'd1))
    else $error("removal reports a reserved slot");

endmodule

bind static_list_symmetric_difference_unit slsd_checker u_slsd_checker (.*);
